// ===== hw/rtl/csa_pkg.sv =====
`default_nettype none
package csa_pkg;

  localparam int ELEM_W    = 16;
  localparam int DOT_W     = 42;
  localparam int SQ_W      = 41;
  localparam int PROD_W    = 2 * SQ_W;
  localparam int HALF_W    = 21;
  localparam int ROOT_W    = 41;
  localparam int SQREM_W   = 43;
  localparam int DVD_W     = 56;
  localparam int DIVREM_W  = 42;
  localparam int FRAC_SH   = 14;
  localparam int RES_W     = 16;
  localparam int CNT_W     = 6;
  localparam int MUL_STEPS  = 4;
  localparam int ROOT_STEPS = 41;
  localparam int DIV_STEPS  = 56;
  localparam logic [14:0] ONE_Q14 = 15'd16384;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ZCHK,
    ST_MUL,
    ST_ROOT,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       acc;
    logic       init;
    logic       mul;
    logic [1:0] mul_sel;
    logic       root;
    logic       div;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic zero_norm;
  } stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/csa_ctrl.sv =====
`default_nettype none
module csa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          in_last_element,
  input  wire csa_pkg::stat_t stat,
  output csa_pkg::cmd_t      cmd,
  output logic               busy
);

  csa_pkg::state_t state_r, state_nxt;
  logic [csa_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= csa_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      csa_pkg::ST_IDLE: begin
        if (start && in_last_element) begin
          state_nxt = csa_pkg::ST_ZCHK;
        end
      end
      csa_pkg::ST_ZCHK: begin
        cnt_nxt = '0;
        if (stat.zero_norm) begin
          state_nxt = csa_pkg::ST_OUT;
        end else begin
          state_nxt = csa_pkg::ST_MUL;
        end
      end
      csa_pkg::ST_MUL: begin
        if (cnt_r == csa_pkg::CNT_W'(csa_pkg::MUL_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = csa_pkg::ST_ROOT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      csa_pkg::ST_ROOT: begin
        if (cnt_r == csa_pkg::CNT_W'(csa_pkg::ROOT_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = csa_pkg::ST_DIV;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      csa_pkg::ST_DIV: begin
        if (cnt_r == csa_pkg::CNT_W'(csa_pkg::DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = csa_pkg::ST_OUT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      csa_pkg::ST_OUT: begin
        state_nxt = csa_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = csa_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = cnt_r[1:0];
    busy        = (state_r != csa_pkg::ST_IDLE);
    unique case (state_r)
      csa_pkg::ST_IDLE: cmd.acc    = start;
      csa_pkg::ST_ZCHK: cmd.init   = 1'b1;
      csa_pkg::ST_MUL:  cmd.mul    = 1'b1;
      csa_pkg::ST_ROOT: cmd.root   = 1'b1;
      csa_pkg::ST_DIV:  cmd.div    = 1'b1;
      csa_pkg::ST_OUT:  cmd.finish = 1'b1;
      default:          cmd        = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/csa_datapath.sv =====
`default_nettype none
module csa_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire csa_pkg::cmd_t                     cmd,
  input  wire logic signed [csa_pkg::ELEM_W-1:0] in_left_element,
  input  wire logic signed [csa_pkg::ELEM_W-1:0] in_right_element,
  input  wire logic                              in_last_element,
  output csa_pkg::stat_t                         stat,
  output logic                                   out_valid,
  output logic signed [csa_pkg::RES_W-1:0]       out_similarity,
  output logic                                   out_zero_norm
);

  logic signed [csa_pkg::DOT_W-1:0] dot_r, dot_nxt, dsum_r;
  logic [csa_pkg::SQ_W-1:0] lsq_r, lsq_nxt, rsq_r, rsq_nxt, lsum_r, rsum_r;
  logic signed [31:0] lr, ll, rr;
  logic signed [csa_pkg::DOT_W:0] dot_ext;
  logic [csa_pkg::SQ_W:0] lsq_ext, rsq_ext;

  logic [csa_pkg::PROD_W-1:0] prod_r, prod_nxt, pp_sh;
  logic [csa_pkg::HALF_W-1:0] op_a, op_b;
  logic [2*csa_pkg::HALF_W-1:0] pp;

  logic [csa_pkg::SQREM_W-1:0] sqrem_r, sqrem_nxt;
  logic [csa_pkg::ROOT_W-1:0] root_r, root_nxt;
  logic [csa_pkg::SQREM_W+1:0] sq_ext, sq_trial;

  logic [csa_pkg::DVD_W-1:0] dvd_r, dvd_nxt, quot_r, quot_nxt;
  logic [csa_pkg::DIVREM_W-1:0] drem_r, drem_nxt;
  logic [csa_pkg::DIVREM_W:0] d_ext, d_den;
  logic [csa_pkg::DOT_W-1:0] mag;

  logic [14:0] q_cl;
  logic [csa_pkg::RES_W-1:0] sim;
  logic valid_r, zero_r;
  logic [csa_pkg::RES_W-1:0] sim_r;

  assign lr = in_left_element * in_right_element;
  assign ll = in_left_element * in_left_element;
  assign rr = in_right_element * in_right_element;

  always_comb begin
    dot_ext = {dot_r[csa_pkg::DOT_W-1], dot_r} + {{(csa_pkg::DOT_W-31){lr[31]}}, lr};
    lsq_ext = {1'b0, lsq_r} + {{(csa_pkg::SQ_W-31){1'b0}}, ll[31:0]};
    rsq_ext = {1'b0, rsq_r} + {{(csa_pkg::SQ_W-31){1'b0}}, rr[31:0]};
    if (dot_ext[csa_pkg::DOT_W] != dot_ext[csa_pkg::DOT_W-1]) begin
      dot_nxt = {dot_ext[csa_pkg::DOT_W], {(csa_pkg::DOT_W-1){~dot_ext[csa_pkg::DOT_W]}}};
    end else begin
      dot_nxt = dot_ext[csa_pkg::DOT_W-1:0];
    end
    lsq_nxt = lsq_ext[csa_pkg::SQ_W] ? '1 : lsq_ext[csa_pkg::SQ_W-1:0];
    rsq_nxt = rsq_ext[csa_pkg::SQ_W] ? '1 : rsq_ext[csa_pkg::SQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r <= '0;
      lsq_r <= '0;
      rsq_r <= '0;
    end else if (cmd.acc) begin
      if (in_last_element) begin
        dot_r  <= '0;
        lsq_r  <= '0;
        rsq_r  <= '0;
      end else begin
        dot_r <= dot_nxt;
        lsq_r <= lsq_nxt;
        rsq_r <= rsq_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc && in_last_element) begin
      dsum_r <= dot_nxt;
      lsum_r <= lsq_nxt;
      rsum_r <= rsq_nxt;
    end
  end

  assign stat.zero_norm = (lsum_r == '0) || (rsum_r == '0);
  assign mag = dsum_r[csa_pkg::DOT_W-1] ? csa_pkg::DOT_W'(-dsum_r) : dsum_r;

  // Square-sum product built from four partial products of 21-bit halves.
  always_comb begin
    op_a = cmd.mul_sel[1] ? {1'b0, lsum_r[csa_pkg::SQ_W-1:csa_pkg::HALF_W]}
                          : lsum_r[csa_pkg::HALF_W-1:0];
    op_b = cmd.mul_sel[0] ? {1'b0, rsum_r[csa_pkg::SQ_W-1:csa_pkg::HALF_W]}
                          : rsum_r[csa_pkg::HALF_W-1:0];
    pp = op_a * op_b;
    unique case (cmd.mul_sel)
      2'd0:    pp_sh = csa_pkg::PROD_W'(pp);
      2'd3:    pp_sh = csa_pkg::PROD_W'(pp) << (2 * csa_pkg::HALF_W);
      default: pp_sh = csa_pkg::PROD_W'(pp) << csa_pkg::HALF_W;
    endcase
  end

  // One result bit per step for both the square root and the division.
  always_comb begin
    sq_ext   = {sqrem_r, prod_r[csa_pkg::PROD_W-1 -: 2]};
    sq_trial = {2'b00, root_r, 2'b01};
    d_ext    = {drem_r, dvd_r[csa_pkg::DVD_W-1]};
    d_den    = {2'b00, root_r};
    prod_nxt  = prod_r;
    sqrem_nxt = sqrem_r;
    root_nxt  = root_r;
    dvd_nxt   = dvd_r;
    drem_nxt  = drem_r;
    quot_nxt  = quot_r;
    priority if (cmd.init) begin
      prod_nxt  = '0;
      sqrem_nxt = '0;
      root_nxt  = '0;
      dvd_nxt   = {mag, {csa_pkg::FRAC_SH{1'b0}}};
      drem_nxt  = '0;
      quot_nxt  = '0;
    end else if (cmd.mul) begin
      prod_nxt = prod_r + pp_sh;
    end else if (cmd.root) begin
      prod_nxt = prod_r << 2;
      if (sq_ext >= sq_trial) begin
        sqrem_nxt = csa_pkg::SQREM_W'(sq_ext - sq_trial);
        root_nxt  = {root_r[csa_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        sqrem_nxt = sq_ext[csa_pkg::SQREM_W-1:0];
        root_nxt  = {root_r[csa_pkg::ROOT_W-2:0], 1'b0};
      end
    end else if (cmd.div) begin
      dvd_nxt = dvd_r << 1;
      if (d_ext >= d_den) begin
        drem_nxt = csa_pkg::DIVREM_W'(d_ext - d_den);
        quot_nxt = {quot_r[csa_pkg::DVD_W-2:0], 1'b1};
      end else begin
        drem_nxt = d_ext[csa_pkg::DIVREM_W-1:0];
        quot_nxt = {quot_r[csa_pkg::DVD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    sqrem_r <= sqrem_nxt;
    root_r  <= root_nxt;
    dvd_r   <= dvd_nxt;
    drem_r  <= drem_nxt;
    quot_r  <= quot_nxt;
  end

  always_comb begin
    q_cl = (quot_r > csa_pkg::DVD_W'(csa_pkg::ONE_Q14)) ? csa_pkg::ONE_Q14 : quot_r[14:0];
    sim  = dsum_r[csa_pkg::DOT_W-1] ? -{1'b0, q_cl} : {1'b0, q_cl};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      zero_r <= stat.zero_norm;
      sim_r  <= stat.zero_norm ? '0 : sim;
    end
  end

  assign out_valid      = valid_r;
  assign out_zero_norm  = zero_r;
  assign out_similarity = sim_r;

endmodule
`default_nettype wire

// ===== hw/rtl/cosine_similarity_accumulator.sv =====
`default_nettype none
// Element pairs without the last mark are taken one per cycle while busy is low;
// they leave busy low. A pair marked last raises busy, which spans the 4 multiply,
// 41 root and 56 divide steps of the shared datapath, then out_valid strobes for
// one cycle. With a zero norm busy skips those steps. The receiver cannot stall.
// Synchronous active-low reset clears the sums and the controller.
module cosine_similarity_accumulator (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [csa_pkg::ELEM_W-1:0] in_left_element,
  input  wire logic signed [csa_pkg::ELEM_W-1:0] in_right_element,
  input  wire logic                              in_last_element,
  output logic                                   out_valid,
  output logic signed [csa_pkg::RES_W-1:0]       out_similarity,
  output logic                                   out_zero_norm
);

  csa_pkg::cmd_t  cmd;
  csa_pkg::stat_t stat;

  csa_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .in_last_element (in_last_element),
    .stat            (stat),
    .cmd             (cmd),
    .busy            (busy)
  );

  csa_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_left_element  (in_left_element),
    .in_right_element (in_right_element),
    .in_last_element  (in_last_element),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_similarity   (out_similarity),
    .out_zero_norm    (out_zero_norm)
  );

`ifndef ASSERT_OFF
  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_zero_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_norm) |-> (out_similarity == '0)) else $error("zero norm");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_similarity <= 16'sd16384 && out_similarity >= -16'sd16384))
    else $error("similarity out of range");
  a_stream: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_last_element) |=> !busy) else $error("stream stalled");
`endif

endmodule
`default_nettype wire
